// ===== rtl/skesc_pkg.sv =====
// Shared types and character constants for the serial key escape decoder.
`default_nettype none

package skesc_pkg;

   // Operation codes carried in each request word.
   localparam logic [1:0] OP_BYTE   = 2'd0;
   localparam logic [1:0] OP_BUTTON = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   // Characters the parser recognises.
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_DIGIT_0   = 8'h30;
   localparam logic [7:0] CH_DIGIT_9   = 8'h39;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_B   = 8'h42;
   localparam logic [7:0] CH_UPPER_C   = 8'h43;
   localparam logic [7:0] CH_UPPER_D   = 8'h44;
   localparam logic [7:0] CH_UPPER_P   = 8'h50;
   localparam logic [7:0] CH_UPPER_Q   = 8'h51;
   localparam logic [7:0] CH_UPPER_S   = 8'h53;
   localparam logic [7:0] CH_UPPER_W   = 8'h57;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_D   = 8'h64;
   localparam logic [7:0] CH_LOWER_P   = 8'h70;
   localparam logic [7:0] CH_LOWER_Q   = 8'h71;
   localparam logic [7:0] CH_LOWER_S   = 8'h73;
   localparam logic [7:0] CH_LOWER_W   = 8'h77;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   // Arrow flag positions.
   localparam logic [3:0] ARROW_UP    = 4'b0001;
   localparam logic [3:0] ARROW_DOWN  = 4'b0010;
   localparam logic [3:0] ARROW_LEFT  = 4'b0100;
   localparam logic [3:0] ARROW_RIGHT = 4'b1000;

   // Letter flag positions.
   localparam logic [6:0] LETTER_W = 7'b0000001;
   localparam logic [6:0] LETTER_S = 7'b0000010;
   localparam logic [6:0] LETTER_A = 7'b0000100;
   localparam logic [6:0] LETTER_D = 7'b0001000;
   localparam logic [6:0] LETTER_Q = 7'b0010000;
   localparam logic [6:0] LETTER_P = 7'b0100000;
   localparam logic [6:0] LETTER_B = 7'b1000000;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
      logic       eject_pressed;
      logic       power_pressed;
   } req_item_type;

   typedef struct packed {
      logic [3:0] arrow_keys;
      logic [6:0] letter_keys;
      logic       enter_key;
      logic       backspace_key;
      logic       interrupt_key;
      logic       eject_key;
      logic       power_key;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/skesc_channels.sv =====
// Valid/ready channel interfaces for the request and response words.
`default_nettype none

interface skesc_req_if;
   import skesc_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface skesc_rsp_if;
   import skesc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/serial_key_escape_decoder_core.sv =====
// Top level of the serial key escape decoder: request register, parser, response register.
`default_nettype none

// The decoder turns a stream of request words into key flag words, one response word for
// every request word and in the same order. A request word carries an operation: a received
// serial byte, a sample of the eject and power buttons, or a flush that clears the parser.
// Serial bytes pass through a small escape parser that recognises ESC [ sequences for the
// arrow keys and maps plain letters, enter characters, backspace and backslash to flags.
//
// Both channels use valid/ready; a word moves at a rising clock edge where both are high.
// A request word is captured in the request register, decoded by the parser from that register
// and loaded into the response register, from which its response word is offered. The
// block takes one word per cycle, sustained: the request register empties into the
// response register in the same cycle in which the response register hands its word on,
// so only the response side can slow the flow.
//
// When the receiver holds ready low, the response word waits in its register and one
// further request word is held in the request register; ready on the request side then
// falls until the receiver takes the waiting word. Reset is synchronous and active high:
// it empties both registers and returns the parser to its idle state outside any sequence.

module serial_key_escape_decoder_core (
   input  wire          clock,
   input  wire          reset,
   skesc_req_if.sink    req_chan,
   skesc_rsp_if.source  rsp_chan
);
   import skesc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type decoded;
   logic         out_load;
   logic         req_take;

   // The response register can take a new word when it is empty or being emptied now.
   assign out_load = in_valid_ff && (!out_valid_ff || rsp_chan.ready);

   // The request register is free when it is empty or its word moves on this cycle.
   assign req_chan.ready = !in_valid_ff || out_load;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);

   skesc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (out_load),
      .item    (in_item_ff),
      .result  (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only when their stage takes a word.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.data;
      end
      if (out_load) begin
         out_item_ff <= decoded;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_item_ff;

endmodule

`default_nettype wire

// ===== rtl/skesc_parser.sv =====
// Escape sequence parser state and key decode for one request word.
`default_nettype none

module skesc_parser (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     advance,
   input  wire skesc_pkg::req_item_type item,
   output skesc_pkg::rsp_item_type result
);
   import skesc_pkg::*;

   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_SEEN,
      ESC_SWALLOW
   } esc_state_type;

   esc_state_type esc_ff, esc_in;
   logic          csi_ff, csi_in;

   always_comb begin
      result = '0;
      esc_in = esc_ff;
      csi_in = csi_ff;
      case (item.operation)
         OP_BYTE: begin
            if (item.rx_byte == CH_NUL) begin
               // NUL is dropped in every state.
            end else if (csi_ff) begin
               if (!(item.rx_byte >= CH_DIGIT_0 && item.rx_byte <= CH_DIGIT_9)) begin
                  case (item.rx_byte)
                     CH_UPPER_A: result.arrow_keys = ARROW_UP;
                     CH_UPPER_B: result.arrow_keys = ARROW_DOWN;
                     CH_UPPER_C: result.arrow_keys = ARROW_RIGHT;
                     CH_UPPER_D: result.arrow_keys = ARROW_LEFT;
                     default:    result.arrow_keys = '0;
                  endcase
                  csi_in = 1'b0;
               end
            end else if (esc_ff != ESC_IDLE) begin
               if (esc_ff == ESC_SEEN && item.rx_byte == CH_LBRACKET) begin
                  csi_in = 1'b1;
                  esc_in = ESC_IDLE;
               end else begin
                  esc_in = ESC_SWALLOW;
               end
            end else begin
               case (item.rx_byte)
                  CH_ESC:                   esc_in = ESC_SEEN;
                  CH_UPPER_W, CH_LOWER_W:   result.letter_keys = LETTER_W;
                  CH_UPPER_S, CH_LOWER_S:   result.letter_keys = LETTER_S;
                  CH_UPPER_A, CH_LOWER_A:   result.letter_keys = LETTER_A;
                  CH_UPPER_D, CH_LOWER_D:   result.letter_keys = LETTER_D;
                  CH_UPPER_Q, CH_LOWER_Q:   result.letter_keys = LETTER_Q;
                  CH_UPPER_P, CH_LOWER_P:   result.letter_keys = LETTER_P;
                  CH_UPPER_B, CH_LOWER_B:   result.letter_keys = LETTER_B;
                  CH_BACKSPACE:             result.backspace_key = 1'b1;
                  CH_LF, CH_CR, CH_SPACE:   result.enter_key = 1'b1;
                  CH_BACKSLASH:             result.interrupt_key = 1'b1;
                  default:                  result.letter_keys = '0;
               endcase
            end
         end
         OP_BUTTON: begin
            result.eject_key = item.eject_pressed;
            result.power_key = item.power_pressed;
         end
         OP_FLUSH: begin
            esc_in = ESC_IDLE;
            csi_in = 1'b0;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // State moves only when the word is handed on to the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= ESC_IDLE;
         csi_ff <= 1'b0;
      end else if (advance) begin
         esc_ff <= esc_in;
         csi_ff <= csi_in;
      end
   end

endmodule

`default_nettype wire
